### sv/assert_macros.svh
// Assertion macros shared by the gain mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge out of reset.
`define PSGM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be seen at a clock edge out of reset.
`define PSGM_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PSGM_ASSERT(lbl, clk, rst, prop, msg)
`define PSGM_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

### sv/psgm_pkg.sv
// Types, constants and gain decode shared by the gain mixer modules.
package psgm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 9;
   localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] CARD_EARLY_MIN = 3'd0;
   localparam logic [2:0] CARD_EARLY_MAX = 3'd3;
   localparam logic [2:0] CARD_WIDE      = 3'd6;
   localparam logic [2:0] CARD_TYPE_RST  = 3'd5;

   typedef enum logic [2:0] {
      REG_CARD_TYPE      = 3'd0,
      REG_VOICE_LEVEL    = 3'd1,
      REG_SYNTH_LEVEL    = 3'd2,
      REG_DIGITAL_ACTIVE = 3'd3,
      REG_SYNTH_ENABLE   = 3'd4
   } reg_index_type;

   // Gain tables: level * 256 / N, truncated.
   localparam logic [GAIN_W-1:0] GAIN_DIV3 [4] = '{9'd0, 9'd85, 9'd170, 9'd256};
   localparam logic [GAIN_W-1:0] GAIN_DIV7 [8] = '{
      9'd0, 9'd36, 9'd73, 9'd109, 9'd146, 9'd182, 9'd219, 9'd256};
   localparam logic [GAIN_W-1:0] GAIN_DIV15 [16] = '{
      9'd0, 9'd17, 9'd34, 9'd51, 9'd68, 9'd85, 9'd102, 9'd119,
      9'd136, 9'd153, 9'd170, 9'd187, 9'd204, 9'd221, 9'd238, 9'd256};

   typedef struct packed {
      logic [GAIN_W-1:0] voice_gain;
      logic [GAIN_W-1:0] synth_gain;
      logic              digital_active;
      logic              synth_enable;
   } ctrl_type;

   typedef struct packed {
      logic both;
      logic digital;
      logic synth;
   } mode_type;

   function automatic logic [GAIN_W-1:0] decode_gain(input logic [2:0] card,
                                                     input logic [7:0] level,
                                                     input logic       is_voice);
      logic [GAIN_W-1:0] g;
      if (card inside {[CARD_EARLY_MIN:CARD_EARLY_MAX]}) begin
         if (is_voice) begin
            g = GAIN_DIV3[level[2:1]];
         end else begin
            g = GAIN_DIV7[level[3:1]];
         end
      end else if (card == CARD_WIDE) begin
         g = GAIN_DIV15[level[7:4]];
      end else begin
         g = GAIN_DIV7[level[7:5]];
      end
      return g;
   endfunction

endpackage

### sv/psgm_csr.sv
// Register file behind the APB-style port, with gain decode.
`include "assert_macros.svh"

module psgm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [psgm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [psgm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [psgm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output psgm_pkg::ctrl_type               ctrl
);
   import psgm_pkg::*;

   logic [2:0]    card_type_ff, card_type_in;
   logic [7:0]    voice_level_ff, voice_level_in;
   logic [7:0]    synth_level_ff, synth_level_in;
   logic          digital_active_ff, digital_active_in;
   logic          synth_enable_ff, synth_enable_in;
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      card_type_in      = card_type_ff;
      voice_level_in    = voice_level_ff;
      synth_level_in    = synth_level_ff;
      digital_active_in = digital_active_ff;
      synth_enable_in   = synth_enable_ff;
      if (wr_en) begin
         case (idx)
            REG_CARD_TYPE:      card_type_in      = csr_pwdata[2:0];
            REG_VOICE_LEVEL:    voice_level_in    = csr_pwdata[7:0];
            REG_SYNTH_LEVEL:    synth_level_in    = csr_pwdata[7:0];
            REG_DIGITAL_ACTIVE: digital_active_in = csr_pwdata[0];
            REG_SYNTH_ENABLE:   synth_enable_in   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         card_type_ff      <= CARD_TYPE_RST;
         voice_level_ff    <= 8'd0;
         synth_level_ff    <= 8'd0;
         digital_active_ff <= 1'b0;
         synth_enable_ff   <= 1'b1;
      end else begin
         card_type_ff      <= card_type_in;
         voice_level_ff    <= voice_level_in;
         synth_level_ff    <= synth_level_in;
         digital_active_ff <= digital_active_in;
         synth_enable_ff   <= synth_enable_in;
      end
   end

   always_comb begin
      case (idx)
         REG_CARD_TYPE:      csr_prdata = {{(CSR_DATA_W-3){1'b0}}, card_type_ff};
         REG_VOICE_LEVEL:    csr_prdata = {{(CSR_DATA_W-8){1'b0}}, voice_level_ff};
         REG_SYNTH_LEVEL:    csr_prdata = {{(CSR_DATA_W-8){1'b0}}, synth_level_ff};
         REG_DIGITAL_ACTIVE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, digital_active_ff};
         REG_SYNTH_ENABLE:   csr_prdata = {{(CSR_DATA_W-1){1'b0}}, synth_enable_ff};
         default:            csr_prdata = '0;
      endcase
   end

   assign ctrl.voice_gain     = decode_gain(card_type_ff, voice_level_ff, 1'b1);
   assign ctrl.synth_gain     = decode_gain(card_type_ff, synth_level_ff, 1'b0);
   assign ctrl.digital_active = digital_active_ff;
   assign ctrl.synth_enable   = synth_enable_ff;

   `PSGM_ASSERT(a_card_type_write, clock, reset, wr_en && idx == REG_CARD_TYPE |=> card_type_ff == $past(csr_pwdata[2:0]), "card type write lost")

endmodule

### sv/psgm_scale.sv
// One gain lane: multiply a sample by its gain, then divide by 256 toward zero.
module psgm_scale (
   input  logic                                clock,
   input  logic                                en_mul,
   input  logic                                en_trunc,
   input  logic signed [psgm_pkg::SAMPLE_W-1:0] sample,
   input  logic        [psgm_pkg::GAIN_W-1:0]   gain,
   output logic signed [psgm_pkg::SAMPLE_W-1:0] scaled
);
   import psgm_pkg::*;

   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic        [PROD_W-1:0]   prod_adj;
   logic signed [SAMPLE_W-1:0] scaled_ff, scaled_in;

   assign prod_in = PROD_W'(sample) * PROD_W'($signed({1'b0, gain}));

   // Bias negative products by 255 so the shift truncates toward zero.
   assign prod_adj  = prod_ff + {{(PROD_W-8){1'b0}}, {8{prod_ff[PROD_W-1]}}};
   assign scaled_in = $signed(prod_adj[SAMPLE_W+7:8]);

   always_ff @(posedge clock) begin
      if (en_mul) begin
         prod_ff <= prod_in;
      end
      if (en_trunc) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

### sv/psgm_mix.sv
// Two-source combine: offset, product and sum, then the clamped mix formula; or one source passed through.
`include "assert_macros.svh"

module psgm_mix (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en_prep,
   input  logic                                 en_out,
   input  logic                                 prep_valid,
   input  logic signed [psgm_pkg::SAMPLE_W-1:0] scaled_digital,
   input  logic signed [psgm_pkg::SAMPLE_W-1:0] scaled_synth,
   input  psgm_pkg::mode_type                   mode,
   output logic        [psgm_pkg::SAMPLE_W-1:0] mixed
);
   import psgm_pkg::*;

   logic [SAMPLE_W-1:0]     a, b;
   logic [2*SAMPLE_W-1:0]   prod_ff, prod_in;
   logic [SAMPLE_W:0]       sum_ff, sum_in;
   logic                    low_ff, low_in;
   logic [SAMPLE_W-1:0]     single_ff, single_in;
   mode_type                mode_ff;
   logic [SAMPLE_W:0]       quot;
   logic [SAMPLE_W+2:0]     m_wide;
   logic [SAMPLE_W-1:0]     m_clamped;
   logic [SAMPLE_W-1:0]     mixed_ff, mixed_in;

   // Offset to unsigned by flipping the sign bit.
   assign a       = {~scaled_digital[SAMPLE_W-1], scaled_digital[SAMPLE_W-2:0]};
   assign b       = {~scaled_synth[SAMPLE_W-1], scaled_synth[SAMPLE_W-2:0]};
   assign prod_in = (2*SAMPLE_W)'(a) * (2*SAMPLE_W)'(b);
   assign sum_in  = {1'b0, a} + {1'b0, b};
   assign low_in  = scaled_digital[SAMPLE_W-1] || scaled_synth[SAMPLE_W-1];

   always_comb begin
      if (mode.digital) begin
         single_in = scaled_digital;
      end else if (mode.synth) begin
         single_in = scaled_synth;
      end else begin
         single_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en_prep) begin
         prod_ff   <= prod_in;
         sum_ff    <= sum_in;
         low_ff    <= low_in;
         single_ff <= single_in;
         mode_ff   <= mode;
      end
      if (en_out) begin
         mixed_ff <= mixed_in;
      end
   end

   // Upper branch: 2(a+b) - ab/32768 - 65536, which lands in 32768..65536.
   assign quot   = prod_ff[2*SAMPLE_W-1:SAMPLE_W-1];
   assign m_wide = {1'b0, sum_ff, 1'b0} - {2'b00, quot}
                   - {2'b00, 1'b1, {SAMPLE_W{1'b0}}};

   always_comb begin
      if (low_ff) begin
         m_clamped = quot[SAMPLE_W-1:0];
      end else if (m_wide[SAMPLE_W]) begin
         m_clamped = {SAMPLE_W{1'b1}};
      end else begin
         m_clamped = m_wide[SAMPLE_W-1:0];
      end
      if (mode_ff.both) begin
         mixed_in = {~m_clamped[SAMPLE_W-1], m_clamped[SAMPLE_W-2:0]};
      end else begin
         mixed_in = single_ff;
      end
   end

   assign mixed = mixed_ff;

   `PSGM_ASSERT_NEVER(a_mix_range, clock, reset, prep_valid && mode_ff.both && !low_ff && (m_wide[SAMPLE_W+2:SAMPLE_W+1] != 2'b00), "mix result out of range")

endmodule

### sv/pcm_synth_gain_mixer.sv
// Top level of the PCM and synthesizer gain mixer.
// Mixes one digital PCM sample with one synthesizer sample per request. Gains are
// decoded from the emulated mixer bytes by card type; each sample is scaled by
// gain/256 toward zero and, when both sources are on, the two are combined with the
// Toth formula, clamped to 16 bits. The datapath is five register stages (capture,
// gain multiply, truncate, offset product, combine), and one request is taken every
// cycle while the output is not stalled; a stalled output holds only the stages behind
// it until the empty stages ahead have filled up. The user must write registers over
// the csr port only while no request is in flight; the block does not enforce this.
`include "assert_macros.svh"

module pcm_synth_gain_mixer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,  // [15:0] digital_sample, [31:16] synth_sample
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // [15:0] mixed_sample
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [psgm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [psgm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [psgm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import psgm_pkg::*;

   localparam int NUM_STAGES = 5;

   ctrl_type                   ctrl;
   logic [NUM_STAGES:1]        valid_ff, valid_in;
   logic [NUM_STAGES:1]        adv;
   logic signed [SAMPLE_W-1:0] digital_ff, synth_ff;
   logic [GAIN_W-1:0]          voice_gain_ff, synth_gain_ff;
   mode_type                   mode1_ff, mode1_in, mode2_ff, mode3_ff;
   logic signed [SAMPLE_W-1:0] scaled_digital, scaled_synth;

   psgm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ctrl        (ctrl)
   );

   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      adv[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_tready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[1] = req_tvalid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_tready = adv[1];
   assign rsp_tvalid = valid_ff[NUM_STAGES];

   assign mode1_in.both    = ctrl.digital_active && ctrl.synth_enable;
   assign mode1_in.digital = ctrl.digital_active && !ctrl.synth_enable;
   assign mode1_in.synth   = !ctrl.digital_active && ctrl.synth_enable;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         digital_ff    <= req_tdata[SAMPLE_W-1:0];
         synth_ff      <= req_tdata[2*SAMPLE_W-1:SAMPLE_W];
         voice_gain_ff <= ctrl.voice_gain;
         synth_gain_ff <= ctrl.synth_gain;
         mode1_ff      <= mode1_in;
      end
      if (adv[2]) begin
         mode2_ff <= mode1_ff;
      end
      if (adv[3]) begin
         mode3_ff <= mode2_ff;
      end
   end

   psgm_scale u_scale_digital (
      .clock    (clock),
      .en_mul   (adv[2]),
      .en_trunc (adv[3]),
      .sample   (digital_ff),
      .gain     (voice_gain_ff),
      .scaled   (scaled_digital)
   );

   psgm_scale u_scale_synth (
      .clock    (clock),
      .en_mul   (adv[2]),
      .en_trunc (adv[3]),
      .sample   (synth_ff),
      .gain     (synth_gain_ff),
      .scaled   (scaled_synth)
   );

   psgm_mix u_mix (
      .clock          (clock),
      .reset          (reset),
      .en_prep        (adv[4]),
      .en_out         (adv[5]),
      .prep_valid     (valid_ff[4]),
      .scaled_digital (scaled_digital),
      .scaled_synth   (scaled_synth),
      .mode           (mode3_ff),
      .mixed          (rsp_tdata)
   );

   `PSGM_ASSERT(a_ready_follows_sink, clock, reset, rsp_tready |-> req_tready, "input stalled while output drains")
   `PSGM_ASSERT(a_stage1_held, clock, reset, valid_ff[1] && !adv[2] |=> valid_ff[1], "stalled request dropped")

endmodule

### sim/pcm_synth_gain_mixer_tb.sv
// Self-checking testbench for the PCM and synthesizer gain mixer.
`timescale 1ns / 1ps

module pcm_synth_gain_mixer_tb;
   import psgm_pkg::*;

   localparam int REG_STRIDE      = 4;
   localparam int FIRST_UNMAPPED  = 5;
   localparam int RANDOM_ITEMS    = 1900;
   localparam int STEADY_TAIL     = 150;
   localparam int DRAIN_CYCLES    = 8;
   localparam int QUIET_LIMIT     = 2000;
   localparam int REPORT_LIMIT    = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;    // [15:0] digital_sample, [31:16] synth_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;         // [15:0] mixed_sample
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pcm_synth_gain_mixer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   typedef struct {
      bit          set_cfg;
      logic [2:0]  card;
      logic [7:0]  voice;
      logic [7:0]  synth;
      bit          dact;
      bit          sen;
      logic [15:0] digital;
      logic [15:0] synth_in;
      bit          known;
      logic [15:0] mixed;
   } mix_case_type;

   mix_case_type mix_cases[$];
   logic [15:0]  mixed_due[$];

   // Shadow copy of the mixer registers.
   logic [2:0]  cfg_card  = CARD_TYPE_RST;
   logic [7:0]  cfg_voice = 8'h00;
   logic [7:0]  cfg_synth = 8'h00;
   bit          cfg_dact  = 1'b0;
   bit          cfg_sen   = 1'b1;

   int          mismatches = 0;
   bit          no_idle = 1'b0;
   int          stall_left = 0;
   logic [15:0] due_mix;

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endfunction

   function automatic int mixer_gain(logic [7:0] level, bit is_voice);
      if (cfg_card <= CARD_EARLY_MAX) begin
         if (is_voice) return int'(level[2:1]) * 256 / 3;
         return int'(level[3:1]) * 256 / 7;
      end
      if (cfg_card == CARD_WIDE) return int'(level[7:4]) * 256 / 15;
      return int'(level[7:5]) * 256 / 7;
   endfunction

   function automatic logic [15:0] mix_samples(logic signed [15:0] digital,
                                               logic signed [15:0] synth_in);
      int     scaled_d;
      int     scaled_s;
      longint a;
      longint b;
      longint m;
      scaled_d = (int'(digital) * mixer_gain(cfg_voice, 1'b1)) / 256;
      scaled_s = (int'(synth_in) * mixer_gain(cfg_synth, 1'b0)) / 256;
      if (cfg_dact && cfg_sen) begin
         a = longint'(scaled_d) + 32768;
         b = longint'(scaled_s) + 32768;
         if (a < 32768 || b < 32768) begin
            m = (a * b) / 32768;
         end else begin
            m = (a + b) * 2 - (a * b) / 32768 - 65536;
         end
         if (m >= 65536) m = 65535;
         if (m < 0) m = 0;
         return 16'(m - 32768);
      end
      if (cfg_dact) return 16'(scaled_d);
      if (cfg_sen) return 16'(scaled_s);
      return 16'h0000;
   endfunction

   function automatic void add_case(bit set_cfg, logic [2:0] card, logic [7:0] voice,
                                    logic [7:0] synth, bit dact, bit sen,
                                    logic [15:0] digital, logic [15:0] synth_in,
                                    bit known, logic [15:0] mixed);
      mix_case_type c;
      c.set_cfg  = set_cfg;
      c.card     = card;
      c.voice    = voice;
      c.synth    = synth;
      c.dact     = dact;
      c.sen      = sen;
      c.digital  = digital;
      c.synth_in = synth_in;
      c.known    = known;
      c.mixed    = mixed;
      mix_cases.push_back(c);
   endfunction

   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               3: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         1, 2: return 16'(int'($urandom_range(0, 512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] random_level();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Start each access at a rising edge; psel stays high for back-to-back accesses.
   task automatic csr_access(input bit wr, input int idx, input logic [31:0] data,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(idx * REG_STRIDE);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   task automatic set_reg(input int idx, input logic [31:0] value, input int width);
      logic [31:0] data;
      logic [31:0] rd;
      data = value;
      // Garbage above the register width must be dropped.
      if ($urandom_range(0, 1)) data = ($urandom << width) | value;
      case (idx)
         REG_CARD_TYPE:      cfg_card  = value[2:0];
         REG_VOICE_LEVEL:    cfg_voice = value[7:0];
         REG_SYNTH_LEVEL:    cfg_synth = value[7:0];
         REG_DIGITAL_ACTIVE: cfg_dact  = value[0];
         REG_SYNTH_ENABLE:   cfg_sen   = value[0];
         default: ;
      endcase
      csr_access(1'b1, idx, data, rd);
      csr_access(1'b0, idx, '0, rd);
      if (rd !== value) note_mismatch("register readback", value, rd);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (mixed_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [2:0] card, input logic [7:0] voice,
                                 input logic [7:0] synth, input bit dact, input bit sen);
      logic [31:0] rd;
      wait_drained();
      set_reg(REG_CARD_TYPE, 32'(card), 3);
      set_reg(REG_VOICE_LEVEL, 32'(voice), 8);
      set_reg(REG_SYNTH_LEVEL, 32'(synth), 8);
      set_reg(REG_DIGITAL_ACTIVE, 32'(dact), 1);
      set_reg(REG_SYNTH_ENABLE, 32'(sen), 1);
      // A write past the register list must leave everything alone.
      if ($urandom_range(0, 3) == 0)
         csr_access(1'b1, FIRST_UNMAPPED + $urandom_range(0, 2), $urandom, rd);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_sample(input logic [15:0] digital, input logic [15:0] synth_in,
                              input bit known, input logic [15:0] mixed);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {synth_in, digital};
      do @(posedge clock); while (!req_tready);
      mixed_due.push_back(known ? mixed : mix_samples(digital, synth_in));
   endtask

   // Result side: check against the oldest request and shape rsp_tready.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mixed_due.size() == 0) begin
            note_mismatch("result with nothing pending", '0, rsp_tdata);
         end else begin
            due_mix = mixed_due.pop_front();
            if (rsp_tdata !== due_mix) note_mismatch("mixed_sample", due_mix, rsp_tdata);
         end
      end
      if (no_idle) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("no handshake for %0d cycles, giving up", QUIET_LIMIT);
      $display("[pcm_synth_gain_mixer] ERROR");
      $finish;
   end

   initial begin : stimulus
      int          sent;
      int          settings;
      int          n;
      int          pick;
      logic [2:0]  card;
      bit          dact;
      bit          sen;

      // Reset defaults: synth only, gain zero.
      add_case(0, 0, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 1, 16'h0000);
      add_case(0, 0, 0, 0, 0, 0, 16'h8000, 16'h7FFF, 1, 16'h0000);
      // Unity gains, one source at a time, then none.
      add_case(1, 6, 8'hFF, 8'hFF, 1, 0, 16'h7FFF, 16'h0000, 1, 16'h7FFF);
      add_case(0, 0, 0, 0, 0, 0, 16'h8000, 16'h7FFF, 1, 16'h8000);
      add_case(1, 6, 8'hFF, 8'hFF, 0, 1, 16'h0000, 16'h7FFF, 1, 16'h7FFF);
      add_case(0, 0, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 1, 16'h8000);
      add_case(1, 6, 8'hFF, 8'hFF, 0, 0, 16'h7FFF, 16'h7FFF, 1, 16'h0000);
      // Both sources: midpoint, floor, overflow clamp.
      add_case(1, 6, 8'hFF, 8'hFF, 1, 1, 16'h0000, 16'h0000, 1, 16'h0000);
      add_case(0, 0, 0, 0, 0, 0, 16'h8000, 16'h8000, 1, 16'h8000);
      add_case(0, 0, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF, 0, 16'h0000);
      add_case(0, 0, 0, 0, 0, 0, 16'h7FFF, 16'h0001, 0, 16'h0000);
      add_case(0, 0, 0, 0, 0, 0, 16'h8000, 16'h7FFF, 0, 16'h0000);
      add_case(0, 0, 0, 0, 0, 0, 16'h4000, 16'h4000, 0, 16'h0000);
      add_case(0, 0, 0, 0, 0, 0, 16'hC000, 16'h4000, 0, 16'h0000);
      // Card type zero decodes with the early layout; masked fields.
      add_case(1, 0, 8'h06, 8'h0E, 1, 1, 16'h7FFF, 16'h8001, 0, 16'h0000);
      add_case(1, 0, 8'hF9, 8'hF1, 1, 0, 16'h7FFF, 16'h7FFF, 1, 16'h0000);
      // Truncation toward zero on negative samples.
      add_case(1, 1, 8'h02, 8'h04, 1, 1, 16'hFFFF, 16'h0001, 0, 16'h0000);
      add_case(1, 3, 8'h04, 8'h0A, 1, 0, 16'h8001, 16'h0000, 0, 16'h0000);
      // Card type seven decodes with the Pro layout.
      add_case(1, 7, 8'hE0, 8'hE0, 1, 0, 16'h8000, 16'h0000, 1, 16'h8000);
      add_case(1, 7, 8'hE0, 8'hE0, 0, 1, 16'h0000, 16'h7FFF, 1, 16'h7FFF);
      add_case(1, 4, 8'hA0, 8'h60, 1, 1, 16'h1234, 16'hEDCB, 0, 16'h0000);
      add_case(1, 5, 8'h1F, 8'h1F, 1, 1, 16'h7FFF, 16'h8000, 1, 16'h0000);
      add_case(1, 6, 8'h10, 8'hF0, 1, 1, 16'hFFFF, 16'hFF01, 0, 16'h0000);
      add_case(1, 2, 8'h07, 8'h0F, 0, 1, 16'h0000, 16'h8000, 0, 16'h0000);

      sent = 0;
      settings = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (mix_cases[i]) begin
         if (mix_cases[i].set_cfg) begin
            apply_settings(mix_cases[i].card, mix_cases[i].voice, mix_cases[i].synth,
                           mix_cases[i].dact, mix_cases[i].sen);
            settings++;
         end
         send_sample(mix_cases[i].digital, mix_cases[i].synth_in,
                     mix_cases[i].known, mix_cases[i].mixed);
      end

      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: card = 3'd0;
               1: card = CARD_WIDE;
               default: card = 3'd7;
            endcase
         end else begin
            card = 3'($urandom);
         end
         // Favor both sources on, where the mixing formula is exercised.
         pick = $urandom_range(0, 9);
         dact = (pick < 7);
         sen  = (pick < 5) || (pick == 7) || (pick == 8);
         apply_settings(card, random_level(), random_level(), dact, sen);
         settings++;
         no_idle = ($urandom_range(0, 3) == 0);
         n = $urandom_range(40, 120);
         repeat (n) begin
            if (sent >= RANDOM_ITEMS - STEADY_TAIL) no_idle = 1'b1;
            send_sample(random_sample(), random_sample(), 1'b0, '0);
            sent++;
         end
      end

      no_idle = 1'b1;
      wait_drained();

      $display("Mixed %0d directed and %0d random samples over %0d register settings,",
               mix_cases.size(), sent, settings);
      $display("with all card layouts and source modes; %0d mismatches.", mismatches);
      if (mismatches == 0 && mixed_due.size() == 0) begin
         $display("[pcm_synth_gain_mixer] OK");
      end else begin
         $display("[pcm_synth_gain_mixer] ERROR");
      end
      $finish;
   end

endmodule
